### rtl/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants of the LIFO stack with search
// Holds the beat field widths and the command and status codes.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned DEPTH_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_SEARCH = 2'd2
  } command_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

### rtl/lifo_stack_with_search.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search: fixed-depth LIFO stack of signed words with search
// Push, pop and a top-down linear search over the held entries.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   -------   --------------------   ---------------------------------------
//   command   start_i / busy_o       command_i, value_i
//   result    done_o (one cycle)     status_o, popped_data_o, found_o, depth_o
//
// A push, a refused pop, a search on an empty stack and an unused command
// complete without busy_o rising: the next beat may follow at once.
// A successful pop holds busy_o high while the entry memory delivers the
// top word. A search holds busy_o high while it compares the entries one
// at a time, from the top down, until a match or the bottom entry, as the
// entry memory has a single read port.
// The result beat on done_o is registered and cannot be stalled by the
// receiver. Reset empties the stack at once; the entry memory itself is
// not cleared.
module lifo_stack_with_search #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [lss_pkg::CMD_W-1:0]          command_i,
  input  logic signed [lss_pkg::DATA_W-1:0]  value_i,
  output logic                               done_o,
  output logic [lss_pkg::ST_W-1:0]           status_o,
  output logic signed [lss_pkg::DATA_W-1:0]  popped_data_o,
  output logic                               found_o,
  output logic [lss_pkg::DEPTH_W-1:0]        depth_o
);
  import lss_pkg::*;

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // One-hot controller: idle, waiting for popped word, scanning for a key.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_SRCH = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [ADDR_W-1:0]  ptr_q, ptr_d;     // address of the word now on rdata
  logic [DATA_W-1:0]  key_q, key_d;

  logic               done_q, done_d;
  status_e            status_q, status_d;
  logic [DATA_W-1:0]  popped_q, popped_d;
  logic               found_q, found_d;
  logic [DEPTH_W-1:0] depth_q;

  logic               we;
  logic [ADDR_W-1:0]  rd_addr;
  logic [DATA_W-1:0]  rdata;
  logic               full, empty;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  lss_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ADDR_W'(count_q)),
    .wdata_i (value_i),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    key_d    = key_q;
    done_d   = 1'b0;
    status_d = ST_DONE;
    popped_d = '0;
    found_d  = 1'b0;
    we       = 1'b0;
    // From idle, both pop and search start at the top entry.
    rd_addr  = ADDR_W'(count_q - CNT_W'(1));

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (command_i)
            CMD_PUSH: begin
              done_d = 1'b1;
              if (full) begin
                status_d = ST_FULL;
              end else begin
                we      = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            CMD_POP: begin
              if (empty) begin
                done_d   = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                // The top word is being read now; it arrives in the next cycle.
                count_d = count_q - CNT_W'(1);
                state_d = S_POP;
              end
            end
            CMD_SEARCH: begin
              if (empty) begin
                done_d = 1'b1;
              end else begin
                ptr_d   = ADDR_W'(count_q - CNT_W'(1));
                key_d   = value_i;
                state_d = S_SRCH;
              end
            end
            default: begin
              // An unused command code does nothing but answer.
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        done_d   = 1'b1;
        popped_d = rdata;
        state_d  = S_IDLE;
      end
      S_SRCH: begin
        // Prefetch the next lower entry while the current one is compared.
        rd_addr = ptr_q - ADDR_W'(1);
        if (rdata == key_q) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          state_d = S_IDLE;
        end else if (ptr_q == '0) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q - ADDR_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    key_q    <= key_d;
    status_q <= status_d;
    popped_q <= popped_d;
    found_q  <= found_d;
    depth_q  <= DEPTH_W'(count_d);
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign popped_data_o = popped_q;
  assign found_o       = found_q;
  assign depth_o       = depth_q;

  // The fill count never passes the capacity of the stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count beyond capacity");

  // No result beat while a pop or a search is still in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !done_o)
    else $error("result beat while busy");

  // Every result beat follows an accepted command or the end of a long one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start_i && !busy_o) || $past(state_q != S_IDLE)))
    else $error("result beat without a command");

  // A refused push reports a full stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (count_q == CNT_W'(DEPTH)))
    else $error("push refused on a stack that is not full");

  // A search may only start on a stack that holds entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> !empty)
    else $error("search running on an empty stack");

endmodule

### rtl/lss_ram.sv
// ----------------------------------------------------------------------------
// lss_ram: entry store of the stack
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module lss_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [ADDR_W-1:0]              waddr_i,
  input  logic [lss_pkg::DATA_W-1:0]     wdata_i,
  input  logic [ADDR_W-1:0]              raddr_i,
  output logic [lss_pkg::DATA_W-1:0]     rdata_o
);
  import lss_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read-before-write: a word written at one edge is seen from the next read.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
